>>> sv/dcfd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and coefficient table of the dual-channel FIR decimator.
package dcfd_pkg;

	localparam int TAP_COUNT   = 33;
	localparam int DECIMATE_BY = 3;
	localparam int COEF_COUNT  = 33;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int ACC_W    = 32;
	localparam int DIGIT_W  = 4;
	localparam int DIGITS   = SAMPLE_W / DIGIT_W;
	localparam int FRAC_W   = 15;

	localparam int TAP_W   = $clog2(TAP_COUNT);
	localparam int DIG_CW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int PHASE_W = (DECIMATE_BY > 1) ? $clog2(DECIMATE_BY) : 1;
	localparam int CIDX_W  = $clog2(COEF_COUNT);

	localparam int FRAME_W = 3;
	localparam int SLOT_W  = 2;
	localparam int CFG_W   = 3;
	localparam int CIDXR_W = 2;

	localparam logic [CIDXR_W-1:0] REG_FRAME_WORDS = 2'd0;
	localparam logic [CIDXR_W-1:0] REG_MIC_SEL     = 2'd1;
	localparam logic [CIDXR_W-1:0] REG_REF_SEL     = 2'd2;

	localparam logic [FRAME_W-1:0] FRAME_WORDS_RST = 3'd2;
	localparam logic [SLOT_W-1:0]  MIC_SEL_RST     = 2'd0;
	localparam logic [SLOT_W-1:0]  REF_SEL_RST     = 2'd1;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

	localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
		16'sd45, 16'sd12, -16'sd52, -16'sd126, -16'sd132, 16'sd18, 16'sd301,
		16'sd512, 16'sd352, -16'sd302, -16'sd1150, -16'sd1488, -16'sd584,
		16'sd1782, 16'sd4989, 16'sd7771, 16'sd8872, 16'sd7771, 16'sd4989,
		16'sd1782, -16'sd584, -16'sd1488, -16'sd1150, -16'sd302, 16'sd352,
		16'sd512, 16'sd301, 16'sd18, -16'sd132, -16'sd126, -16'sd52,
		16'sd12, 16'sd45
	};

	// Per-cycle control shared by both channels.
	typedef struct packed {
		logic push;   // shift a new sample into the delay line
		logic clear;  // zero the accumulator ahead of a filter pass
		logic step;   // one digit of the multiply-accumulate
		logic first;  // first digit of a tap
		logic last;   // last digit of a tap: accumulate and rotate
	} dcfd_ctl_t;

	// Taps beyond the table use a zero coefficient.
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] tap);
		logic [CIDX_W-1:0] idx;
		idx = CIDX_W'(tap);
		if (int'(tap) < COEF_COUNT) begin
			return COEF_TABLE[idx];
		end
		return '0;
	endfunction

endpackage

>>> sv/dual_channel_fir_decimator.sv
`timescale 1ns / 1ps
// Top level of the dual-channel FIR decimator.
// Usage:
//  - Input channel (in_valid/in_ready): one item is one frame of four slot
//    words. The microphone and reference slots, chosen by the configuration
//    registers, are pushed into their own 33-entry delay lines; a slot at or
//    beyond frame_words pushes zero.
//  - Output channel (out_valid/out_ready): on the first frame after reset and
//    on every third frame after that, one item carries both filtered samples.
//  - A frame that gives no result leaves in_ready high; the next frame can
//    follow in the following cycle.
//  - A frame that gives a result starts a filter pass: 33 taps, each one taken
//    as four 4-bit sample digits times the coefficient, on one MAC per channel.
//    in_ready stays low through the digit steps of the pass until the result
//    register is loaded.
//  - The result register holds its item while the receiver stalls; further
//    frames are still taken meanwhile. A pass that finishes while the register
//    is still full waits, with in_ready low, until the item is taken.
//  - Reset clears both delay lines, the decimation phase and the output valid
//    flag, and sets frame_words to 2, the microphone slot to 0 and the
//    reference slot to 1.
//  - Write configuration (cfg_we, cfg_index, cfg_data) only while idle.
module dual_channel_fir_decimator import dcfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CIDXR_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] slot_word_0,
	input  logic signed [SAMPLE_W-1:0] slot_word_1,
	input  logic signed [SAMPLE_W-1:0] slot_word_2,
	input  logic signed [SAMPLE_W-1:0] slot_word_3,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] mic_filtered,
	output logic signed [SAMPLE_W-1:0] ref_filtered
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                 state_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [TAP_W-1:0]           tap_q;
	logic [DIG_CW-1:0]          dig_q;
	logic [FRAME_W-1:0]         frame_words_q;
	logic [SLOT_W-1:0]          mic_sel_q;
	logic [SLOT_W-1:0]          ref_sel_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] mic_out_q;
	logic signed [SAMPLE_W-1:0] ref_out_q;

	dcfd_ctl_t                  ctl;
	logic                       accept;
	logic                       load_out;
	logic signed [SAMPLE_W-1:0] mic_sample;
	logic signed [SAMPLE_W-1:0] ref_sample;
	logic signed [SAMPLE_W-1:0] mic_res;
	logic signed [SAMPLE_W-1:0] ref_res;
	logic signed [COEF_W-1:0]   coef;

	// Pick a slot word; a slot outside the frame reads as zero.
	function automatic logic signed [SAMPLE_W-1:0] pick_slot(
		input logic [SLOT_W-1:0]          slot,
		input logic [FRAME_W-1:0]         words,
		input logic signed [SAMPLE_W-1:0] w0,
		input logic signed [SAMPLE_W-1:0] w1,
		input logic signed [SAMPLE_W-1:0] w2,
		input logic signed [SAMPLE_W-1:0] w3
	);
		logic signed [SAMPLE_W-1:0] w;
		unique case (slot)
			2'd0:    w = w0;
			2'd1:    w = w1;
			2'd2:    w = w2;
			default: w = w3;
		endcase
		if ({1'b0, slot} >= words) begin
			w = '0;
		end
		return w;
	endfunction

	// Configuration: unused index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q <= FRAME_WORDS_RST;
			mic_sel_q     <= MIC_SEL_RST;
			ref_sel_q     <= REF_SEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WORDS: frame_words_q <= cfg_data;
				REG_MIC_SEL:     mic_sel_q     <= cfg_data[SLOT_W-1:0];
				REG_REF_SEL:     ref_sel_q     <= cfg_data[SLOT_W-1:0];
				default:         ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign mic_sample = pick_slot(mic_sel_q, frame_words_q,
		slot_word_0, slot_word_1, slot_word_2, slot_word_3);
	assign ref_sample = pick_slot(ref_sel_q, frame_words_q,
		slot_word_0, slot_word_1, slot_word_2, slot_word_3);

	// Control shared by both MACs: a pass walks taps, four digits per tap.
	always_comb begin
		ctl.push  = accept;
		ctl.clear = accept && (phase_q == '0);
		ctl.step  = (state_q == ST_CALC);
		ctl.first = (dig_q == '0);
		ctl.last  = (dig_q == DIG_CW'(DIGITS - 1));
	end

	assign coef = coef_at(tap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			tap_q   <= '0;
			dig_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Advance the phase; a frame at phase zero starts a pass.
						phase_q <= (phase_q == PHASE_W'(DECIMATE_BY - 1)) ?
							'0 : phase_q + 1'b1;
						if (phase_q == '0) begin
							state_q <= ST_CALC;
							tap_q   <= '0;
							dig_q   <= '0;
						end
					end
				end
				ST_CALC: begin
					if (ctl.last) begin
						dig_q <= '0;
						if (tap_q == TAP_W'(TAP_COUNT - 1)) begin
							tap_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							tap_q <= tap_q + 1'b1;
						end
					end else begin
						dig_q <= dig_q + 1'b1;
					end
				end
				ST_DONE: begin
					// Hold the finished sums until the result register is free.
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dcfd_chan u_mic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (mic_sample),
		.coef   (coef),
		.result (mic_res)
	);

	dcfd_chan u_ref (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (ref_sample),
		.coef   (coef),
		.result (ref_res)
	);

	// Result register: holds its item across a stalled receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mic_out_q <= mic_res;
			ref_out_q <= ref_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign mic_filtered = mic_out_q;
	assign ref_filtered = ref_out_q;

endmodule

>>> sv/dcfd_chan.sv
`timescale 1ns / 1ps
// One filter channel: shift delay line and digit-serial multiply-accumulate.
module dcfd_chan import dcfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dcfd_ctl_t                  ctl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [COEF_W-1:0]   coef,
	output logic signed [SAMPLE_W-1:0] result
);

	localparam int SH_W = SAMPLE_W - DIGIT_W;

	logic signed [SAMPLE_W-1:0]        line_q [TAP_COUNT];
	logic [SH_W-1:0]                   sh_q;
	logic signed [ACC_W-1:0]           p_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [DIGIT_W:0]           dig_s;
	logic signed [DIGIT_W+COEF_W:0]    prod;
	logic signed [ACC_W-1:0]           prod_x;
	logic signed [ACC_W-1:0]           p_next;
	logic signed [ACC_W-FRAC_W-1:0]    q;

	// Newest sample sits at the head; a filter pass rotates the line once round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				line_q[i] <= '0;
			end
		end else if (ctl.push) begin
			line_q[0] <= sample;
			for (int i = 1; i < TAP_COUNT; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end else if (ctl.step && ctl.last) begin
			for (int i = 0; i < TAP_COUNT - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[TAP_COUNT-1] <= line_q[0];
		end
	end

	// Most significant digit first; only the top digit carries the sign.
	always_comb begin
		if (ctl.first) begin
			dig_s = {line_q[0][SAMPLE_W-1], line_q[0][SAMPLE_W-1 -: DIGIT_W]};
		end else begin
			dig_s = {1'b0, sh_q[SH_W-1 -: DIGIT_W]};
		end
		prod   = dig_s * coef;
		prod_x = {{(ACC_W-DIGIT_W-COEF_W-1){prod[DIGIT_W+COEF_W]}}, prod};
		p_next = (ctl.first ? '0 : (p_q <<< DIGIT_W)) + prod_x;
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			p_q <= p_next;
			if (ctl.first) begin
				sh_q <= line_q[0][SH_W-1:0];
			end else begin
				sh_q <= sh_q << DIGIT_W;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.step && ctl.last) begin
			acc_q <= acc_q + p_next;
		end
	end

	// Floor shift by the fraction width, then saturate.
	always_comb begin
		q = acc_q[ACC_W-1:FRAC_W];
		if (q > (ACC_W-FRAC_W)'(SAT_MAX)) begin
			result = SAT_MAX;
		end else if (q < (ACC_W-FRAC_W)'(SAT_MIN)) begin
			result = SAT_MIN;
		end else begin
			result = q[SAMPLE_W-1:0];
		end
	end

endmodule
